/* design/sct_pkg.sv */
// Package for sphere_cavity_table: shared codes, widths and field types.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package sct_pkg;
  localparam int unsigned CoordW  = 20;
  localparam int unsigned RadW    = 16;
  localparam int unsigned DiffW   = 21;
  localparam int unsigned SqW     = 42;
  localparam int unsigned D2W     = 44;
  localparam int unsigned RootW   = 22;
  localparam int unsigned DepthW  = 18;

  localparam logic [1:0] OpAppend  = 2'd0;
  localparam logic [1:0] OpContain = 2'd1;
  localparam logic [1:0] OpOverlap = 2'd2;

  localparam logic [1:0] StDone   = 2'd0;
  localparam logic [1:0] StOrigin = 2'd1;
  localparam logic [1:0] StSmall  = 2'd2;
  localparam logic [1:0] StFull   = 2'd3;

  typedef struct packed {
    logic              start;
    logic [D2W-1:0]    n;
  } sqrt_req_t;
endpackage
`default_nettype wire

/* design/sct_sqrt.sv */
// Iterative integer square root: two radicand bits in, one root bit out per cycle.
// Depends on sct_pkg.
`timescale 1ns / 1ps
`default_nettype none
module sct_sqrt (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  sct_pkg::sqrt_req_t             req_i,
  output logic                           done_o,
  output logic [sct_pkg::RootW-1:0]      root_o
);
  localparam int unsigned Steps = sct_pkg::D2W / 2;
  localparam int unsigned CntW  = $clog2(Steps + 1);

  logic [sct_pkg::D2W-1:0] rem_q, rem_d, src_q, src_d;
  logic [sct_pkg::RootW-1:0] root_q, root_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic busy_q, busy_d, done_q, done_d;
  logic [sct_pkg::D2W+1:0] trial;
  logic [sct_pkg::D2W+1:0] rem_sh;

  assign rem_sh = {rem_q, src_q[sct_pkg::D2W-1 -: 2]};
  assign trial  = rem_sh - {{(sct_pkg::D2W-sct_pkg::RootW){1'b0}}, root_q, 2'b01};

  always_comb begin
    rem_d  = rem_q;
    src_d  = src_q;
    root_d = root_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (req_i.start) begin
      rem_d  = '0;
      src_d  = req_i.n;
      root_d = '0;
      cnt_d  = CntW'(Steps);
      busy_d = 1'b1;
    end else if (busy_q) begin
      // restoring step: bring down two bits, try root*4+1
      if (!trial[sct_pkg::D2W+1]) begin
        rem_d  = trial[sct_pkg::D2W-1:0];
        root_d = {root_q[sct_pkg::RootW-2:0], 1'b1};
      end else begin
        rem_d  = rem_sh[sct_pkg::D2W-1:0];
        root_d = {root_q[sct_pkg::RootW-2:0], 1'b0};
      end
      src_d = {src_q[sct_pkg::D2W-3:0], 2'b00};
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == CntW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q  <= rem_d;
    src_q  <= src_d;
    root_q <= root_d;
  end

  assign done_o = done_q;
  assign root_o = root_q;
endmodule
`default_nettype wire

/* design/sphere_cavity_table.sv */
// Sphere table top level: storage memory, sequencer and shared distance unit.
// Depends on sct_pkg and sct_sqrt.
`timescale 1ns / 1ps
`default_nettype none
// Holds up to CAPACITY spheres in one synchronous memory (one read, one write
// per cycle, read data registered). Every accepted item passes through the
// output state, so an append, an unused op or a query on an empty table goes
// there straight from acceptance and has its result registered on leaving it.
// A containment query walks every stored entry through a shared distance unit,
// one entry at a time (read, difference, square, sum, compare). An overlap
// query adds a serial square root for each entry. The result register holds
// a finished item while the output waits; one item is in flight at a time, and
// the next item is accepted in the cycle after the result is taken.
// No clearing pass is needed after reset.
module sphere_cavity_table #(
  parameter int unsigned CAPACITY = 256
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [15:0] cfg_wdata_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  op_i,
  input  logic signed [19:0] pos_x_i,
  input  logic signed [19:0] pos_y_i,
  input  logic signed [19:0] pos_z_i,
  input  logic [15:0] sphere_radius_i,
  input  logic        mark_priority_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [1:0]  status_o,
  output logic        found_o,
  output logic [7:0]  hit_index_o,
  output logic [17:0] overlap_depth_o,
  output logic [8:0]  entry_count_o,
  output logic        any_priority_o
);
  localparam int unsigned AW  = $clog2(CAPACITY);
  localparam int unsigned CW  = $clog2(CAPACITY + 1);
  localparam int unsigned EW  = 3 * sct_pkg::CoordW + sct_pkg::RadW;

  localparam logic [2:0] SIdle = 3'd0;
  localparam logic [2:0] SRead = 3'd1;
  localparam logic [2:0] SDiff = 3'd2;
  localparam logic [2:0] SSq   = 3'd3;
  localparam logic [2:0] SSum  = 3'd4;
  localparam logic [2:0] SRoot = 3'd5;
  localparam logic [2:0] SOut  = 3'd6;
  localparam logic [2:0] SCmp  = 3'd7;

  // sphere memory: x, y, z, radius packed in one word
  logic [EW-1:0] mem_q [CAPACITY];
  logic [EW-1:0] rd_q;
  logic          mem_we;
  logic [AW-1:0] rd_addr;

  logic [2:0]  st_q, st_d;
  logic [15:0] min_r_q;
  logic [CW-1:0] count_q, count_d;
  logic        prio_q, prio_d;
  logic [CW-1:0] k_q, k_d;

  // latched item
  logic [1:0]  op_q;
  logic signed [19:0] px_q, py_q, pz_q;
  logic [15:0] r_q;
  logic        mark_q;

  // per-entry datapath
  logic signed [sct_pkg::DiffW-1:0] dx_q, dy_q, dz_q;
  logic [15:0] er_q;
  logic [sct_pkg::SqW-1:0] sx_q, sy_q, sz_q;
  logic [31:0] rr_q;
  logic [sct_pkg::D2W-1:0] d2_q;

  // results
  logic        found_q, found_d;
  logic [7:0]  hit_q, hit_d;
  logic [sct_pkg::D2W-1:0] best_q, best_d;
  logic [sct_pkg::DepthW-1:0] depth_q, depth_d;
  logic [1:0]  stat_q, stat_d;
  logic        ovalid_q, ovalid_d;

  logic accept;
  sct_pkg::sqrt_req_t sq_req;
  logic sq_done;
  logic [sct_pkg::RootW-1:0] sq_root;
  logic [sct_pkg::RootW-1:0] sum_r;
  logic [sct_pkg::RootW:0]   diff_r;

  assign in_ready_o = (st_q == SIdle) && !ovalid_q;
  assign accept     = in_valid_i && in_ready_o;
  assign rd_addr    = k_q[AW-1:0];

  sct_sqrt u_sqrt (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (sq_req),
    .done_o(sq_done),
    .root_o(sq_root)
  );

  assign sum_r  = sct_pkg::RootW'(er_q) + sct_pkg::RootW'(r_q);
  assign diff_r = {1'b0, sum_r} - {1'b0, sq_root};

  always_comb begin
    st_d     = st_q;
    k_d      = k_q;
    count_d  = count_q;
    prio_d   = prio_q;
    found_d  = found_q;
    hit_d    = hit_q;
    best_d   = best_q;
    depth_d  = depth_q;
    stat_d   = stat_q;
    ovalid_d = ovalid_q;
    mem_we   = 1'b0;
    sq_req.start = 1'b0;
    sq_req.n     = d2_q;
    if (ovalid_q && out_ready_i) ovalid_d = 1'b0;
    unique case (st_q)
      SIdle: begin
        if (accept) begin
          k_d     = '0;
          found_d = 1'b0;
          hit_d   = '0;
          best_d  = '0;
          depth_d = '0;
          stat_d  = sct_pkg::StDone;
          st_d    = SOut;
          if (op_i == sct_pkg::OpContain || op_i == sct_pkg::OpOverlap) begin
            if (count_q != '0) st_d = SRead;
          end
        end
      end
      SRead: st_d = SDiff;
      SDiff: st_d = SSq;
      SSq:   st_d = SSum;
      SSum:  st_d = SCmp;
      SCmp: begin
        // squared distance is registered now
        if (op_q == sct_pkg::OpOverlap) begin
          sq_req.start = 1'b1;
          st_d = SRoot;
        end else begin
          // strict containment; earlier entry wins a tie
          if (d2_q < sct_pkg::D2W'(rr_q) && (!found_q || d2_q < best_q)) begin
            found_d = 1'b1;
            best_d  = d2_q;
            hit_d   = 8'(k_q);
          end
          k_d  = k_q + 1'b1;
          st_d = (k_q + 1'b1 == count_q) ? SOut : SRead;
        end
      end
      SRoot: begin
        if (sq_done) begin
          if (!diff_r[sct_pkg::RootW] && diff_r != '0 &&
              diff_r > (sct_pkg::RootW+1)'(depth_q))
            depth_d = sct_pkg::DepthW'(diff_r);
          k_d  = k_q + 1'b1;
          st_d = (k_q + 1'b1 == count_q) ? SOut : SRead;
        end
      end
      SOut: begin
        if (op_q == sct_pkg::OpAppend) begin
          if (px_q == '0 && py_q == '0 && pz_q == '0) stat_d = sct_pkg::StOrigin;
          else if (r_q < min_r_q) stat_d = sct_pkg::StSmall;
          else if (count_q >= CW'(CAPACITY)) stat_d = sct_pkg::StFull;
          else begin
            mem_we  = 1'b1;
            count_d = count_q + 1'b1;
            if (mark_q) prio_d = 1'b1;
          end
        end
        ovalid_d = 1'b1;
        st_d     = SIdle;
      end
      default: st_d = SIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q     <= SIdle;
      min_r_q  <= 16'd256;
      count_q  <= '0;
      prio_q   <= 1'b0;
      ovalid_q <= 1'b0;
      k_q      <= '0;
    end else begin
      st_q     <= st_d;
      count_q  <= count_d;
      prio_q   <= prio_d;
      ovalid_q <= ovalid_d;
      k_q      <= k_d;
      if (cfg_we_i) min_r_q <= cfg_wdata_i;
    end
  end

  // memory: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (mem_we) mem_q[count_q[AW-1:0]] <= {px_q, py_q, pz_q, r_q};
    rd_q <= mem_q[rd_addr];
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q   <= op_i;
      px_q   <= pos_x_i;
      py_q   <= pos_y_i;
      pz_q   <= pos_z_i;
      r_q    <= sphere_radius_i;
      mark_q <= mark_priority_i;
    end
    // difference stage
    dx_q <= sct_pkg::DiffW'(px_q) - sct_pkg::DiffW'(signed'(rd_q[EW-1 -: 20]));
    dy_q <= sct_pkg::DiffW'(py_q) - sct_pkg::DiffW'(signed'(rd_q[EW-21 -: 20]));
    dz_q <= sct_pkg::DiffW'(pz_q) - sct_pkg::DiffW'(signed'(rd_q[EW-41 -: 20]));
    if (st_q == SDiff) er_q <= rd_q[15:0];
    // square stage
    sx_q <= sct_pkg::SqW'(dx_q * dx_q);
    sy_q <= sct_pkg::SqW'(dy_q * dy_q);
    sz_q <= sct_pkg::SqW'(dz_q * dz_q);
    rr_q <= er_q * er_q;
    // sum stage
    d2_q <= sct_pkg::D2W'(sx_q) + sct_pkg::D2W'(sy_q) + sct_pkg::D2W'(sz_q);
    found_q <= found_d;
    hit_q   <= hit_d;
    best_q  <= best_d;
    depth_q <= depth_d;
    stat_q  <= stat_d;
  end

  assign out_valid_o     = ovalid_q;
  assign status_o        = stat_q;
  assign found_o         = found_q;
  assign hit_index_o     = hit_q;
  assign overlap_depth_o = depth_q;
  assign entry_count_o   = 9'(count_q);
  assign any_priority_o  = prio_q;
endmodule
`default_nettype wire

/* sim/sphere_cavity_table_tb.sv */
// Testbench for sphere_cavity_table: a directed table, then random traffic checked
// against an in-bench sphere table predictor. Depends on sct_pkg and the RTL.
`timescale 1ns / 1ps
module sphere_cavity_table_tb;

  localparam logic [1:0] OpIdle = 2'd3;  // unused opcode: block only reports state
  localparam int unsigned Depth = 256;
  localparam longint Limit = 20000000;

  typedef struct {
    logic [1:0]         op;
    logic signed [19:0] x, y, z;
    logic [15:0]        rad;
    logic               mark;
  } sphere_req_t;

  typedef struct {
    logic [1:0]  status;
    logic        found;
    logic [7:0]  hit;
    logic [17:0] depth;
    logic [8:0]  count;
    logic        prio;
  } sphere_rsp_t;

  typedef struct {
    bit          cfg_en;     // write min_radius before this row
    logic [15:0] cfg_val;
    sphere_req_t req;
    bit          typed;      // expected response given in the row
    sphere_rsp_t rsp;
  } step_row_t;

  logic clk, rst_n;
  logic cfg_we;
  logic [15:0] cfg_wdata;
  logic in_valid, in_ready, out_valid, out_ready;
  logic [1:0] op;
  logic signed [19:0] pos_x, pos_y, pos_z;
  logic [15:0] radius;
  logic mark;
  logic [1:0] status;
  logic found, any_prio;
  logic [7:0] hit_index;
  logic [17:0] depth;
  logic [8:0] entry_count;

  sphere_cavity_table u_dut (
    .clk_i(clk), .rst_ni(rst_n),
    .cfg_we_i(cfg_we), .cfg_wdata_i(cfg_wdata),
    .in_valid_i(in_valid), .in_ready_o(in_ready),
    .op_i(op), .pos_x_i(pos_x), .pos_y_i(pos_y), .pos_z_i(pos_z),
    .sphere_radius_i(radius), .mark_priority_i(mark),
    .out_valid_o(out_valid), .out_ready_i(out_ready),
    .status_o(status), .found_o(found), .hit_index_o(hit_index),
    .overlap_depth_o(depth), .entry_count_o(entry_count),
    .any_priority_o(any_prio)
  );

  // Shadow copy of the sphere table
  logic signed [19:0] tab_x [Depth];
  logic signed [19:0] tab_y [Depth];
  logic signed [19:0] tab_z [Depth];
  logic [15:0]        tab_r [Depth];
  int unsigned        tab_count;
  logic               tab_prio;
  logic [15:0]        min_radius;

  sphere_rsp_t pending_rsp[$];
  int  errors;
  bit  calm;          // no idling on either side
  int  hold_req;      // long receiver hold-off, picked up by the receiver
  longint cycles;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > Limit) begin
      $display("status: fail");
      $finish;
    end
  end

  function automatic longint unsigned sq_dist(sphere_req_t q, int k);
    longint dx, dy, dz;
    dx = longint'(q.x) - longint'(tab_x[k]);
    dy = longint'(q.y) - longint'(tab_y[k]);
    dz = longint'(q.z) - longint'(tab_z[k]);
    return longint'(dx * dx + dy * dy + dz * dz);
  endfunction

  // Floor square root, built one bit at a time from the top
  function automatic longint unsigned floor_root(longint unsigned n);
    longint unsigned root, trial;
    root = 0;
    for (int b = 22; b >= 0; b--) begin
      trial = root | (longint'(1) << b);
      if (trial * trial <= n) root = trial;
    end
    return root;
  endfunction

  // Apply one request to the shadow table and return the response it gives
  function automatic sphere_rsp_t sphere_step(sphere_req_t q);
    sphere_rsp_t r;
    longint unsigned best, d2, rr, sum, gap, deepest;
    r = '{default: '0};
    best = 0;
    deepest = 0;
    case (q.op)
      sct_pkg::OpAppend: begin
        if (q.x == 0 && q.y == 0 && q.z == 0) r.status = sct_pkg::StOrigin;
        else if (q.rad < min_radius) r.status = sct_pkg::StSmall;
        else if (tab_count >= Depth) r.status = sct_pkg::StFull;
        else begin
          tab_x[tab_count] = q.x;
          tab_y[tab_count] = q.y;
          tab_z[tab_count] = q.z;
          tab_r[tab_count] = q.rad;
          tab_count++;
          if (q.mark) tab_prio = 1'b1;
          r.status = sct_pkg::StDone;
        end
      end
      sct_pkg::OpContain: begin
        for (int k = 0; k < tab_count; k++) begin
          d2 = sq_dist(q, k);
          rr = longint'(tab_r[k]) * longint'(tab_r[k]);
          // strict containment; an equal distance keeps the earlier hit
          if (d2 < rr && (!r.found || d2 < best)) begin
            best = d2;
            r.found = 1'b1;
            r.hit = k[7:0];
          end
        end
      end
      sct_pkg::OpOverlap: begin
        for (int k = 0; k < tab_count; k++) begin
          gap = floor_root(sq_dist(q, k));
          sum = longint'(tab_r[k]) + longint'(q.rad);
          if (sum > gap && sum - gap > deepest) deepest = sum - gap;
        end
        r.depth = deepest[17:0];
      end
      default: ;
    endcase
    r.count = tab_count[8:0];
    r.prio = tab_prio;
    return r;
  endfunction

  // Response checker
  always @(posedge clk) begin
    sphere_rsp_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_rsp.size() == 0) begin
        $display("%0t: unexpected response, status %0d count %0d", $time, status,
                 entry_count);
        errors++;
      end else begin
        want = pending_rsp.pop_front();
        if (status !== want.status) begin
          $display("%0t: status exp %0d got %0d", $time, want.status, status);
          errors++;
        end
        if (found !== want.found) begin
          $display("%0t: found exp %0d got %0d", $time, want.found, found);
          errors++;
        end
        if (hit_index !== want.hit) begin
          $display("%0t: hit_index exp %0d got %0d", $time, want.hit, hit_index);
          errors++;
        end
        if (depth !== want.depth) begin
          $display("%0t: overlap_depth exp %0d got %0d", $time, want.depth, depth);
          errors++;
        end
        if (entry_count !== want.count) begin
          $display("%0t: entry_count exp %0d got %0d", $time, want.count, entry_count);
          errors++;
        end
        if (any_prio !== want.prio) begin
          $display("%0t: any_priority exp %0d got %0d", $time, want.prio, any_prio);
          errors++;
        end
      end
    end
  end

  // Receiver: random stall bursts, plus one long hold-off on request
  initial begin
    int burst;
    int hold;
    burst = 0;
    hold = 0;
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req > 0) begin
        hold = hold_req;
        hold_req = 0;
      end
      if (hold > 0) begin
        hold--;
        out_ready = 1'b0;
      end else if (burst > 0) begin
        burst--;
        out_ready = 1'b0;
      end else if (!calm && $urandom_range(0, 4) == 0) begin
        burst = $urandom_range(0, 5);
        out_ready = 1'b0;
      end else begin
        out_ready = 1'b1;
      end
    end
  end

  // Wait at a falling edge until every response has come back
  task automatic drain();
    @(negedge clk);
    while (pending_rsp.size() != 0) @(negedge clk);
  endtask

  task automatic write_min_radius(input logic [15:0] v);
    drain();
    cfg_we = 1'b1;
    cfg_wdata = v;
    @(negedge clk);
    cfg_we = 1'b0;
    min_radius = v;
  endtask

  // Offer one item from a falling edge; return at the falling edge after acceptance
  task automatic offer(input sphere_req_t q, input bit typed, input sphere_rsp_t want);
    sphere_rsp_t got;
    if (!calm && $urandom_range(0, 3) == 0) begin
      in_valid = 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk);
    end
    in_valid = 1'b1;
    op = q.op;
    pos_x = q.x;
    pos_y = q.y;
    pos_z = q.z;
    radius = q.rad;
    mark = q.mark;
    do @(posedge clk); while (!in_ready);
    got = sphere_step(q);
    pending_rsp.push_back(typed ? want : got);
    @(negedge clk);
    // drop valid; a following offer that does not idle raises it again in the same time step
    in_valid = 1'b0;
  endtask

  function automatic logic signed [19:0] near(logic signed [19:0] c, int span);
    int v;
    v = int'(c) + $urandom_range(0, 2 * span) - span;
    return v[19:0];
  endfunction

  // Random request; appends stop growing the table once it holds cap entries
  function automatic sphere_req_t pick_req(int unsigned cap);
    sphere_req_t q;
    int sel, k, span;
    sel = $urandom_range(0, 99);
    q.x = $urandom;
    q.y = $urandom;
    q.z = $urandom;
    q.rad = $urandom;
    q.mark = $urandom;
    if (sel < 30) begin
      q.op = sct_pkg::OpAppend;
      if ($urandom_range(0, 7) != 0) begin
        q.x = $urandom_range(0, 40000) - 20000;
        q.y = $urandom_range(0, 40000) - 20000;
        q.z = $urandom_range(0, 40000) - 20000;
      end
      if ($urandom_range(0, 9) != 0)
        q.rad = (int'(min_radius) + $urandom_range(0, 8000) > 65535) ? 16'hffff :
                16'(int'(min_radius) + $urandom_range(0, 8000));
      if (q.x == 0 && q.y == 0 && q.z == 0) q.x = 1;
      if ($urandom_range(0, 19) == 0 || tab_count >= cap) begin
        // rejected: origin centre or undersized radius
        if (min_radius != 0 && $urandom_range(0, 1) == 1)
          q.rad = $urandom_range(0, int'(min_radius) - 1);
        else begin
          q.x = 0;
          q.y = 0;
          q.z = 0;
        end
      end
    end else if (sel < 95) begin
      q.op = (sel < 65) ? sct_pkg::OpContain : sct_pkg::OpOverlap;
      if (sel >= 65 && $urandom_range(0, 1) == 1) q.rad = $urandom_range(0, 4000);
      if (tab_count > 0 && $urandom_range(0, 4) < 3) begin
        k = $urandom_range(0, tab_count - 1);
        span = int'(tab_r[k]) + 1;
        q.x = near(tab_x[k], span);
        q.y = near(tab_y[k], span);
        q.z = near(tab_z[k], span);
      end
    end else begin
      q.op = OpIdle;
    end
    return q;
  endfunction

  task automatic run_random(input int n, input int unsigned cap);
    sphere_rsp_t none;
    none = '{default: '0};
    repeat (n) offer(pick_req(cap), 1'b0, none);
  endtask

  function automatic step_row_t row(bit ce, logic [15:0] cv, logic [1:0] o,
                                    int x, int y, int z, int r, bit m,
                                    bit typed = 0, logic [1:0] st = sct_pkg::StDone,
                                    bit f = 0, int h = 0, int d = 0, int c = 0,
                                    bit p = 0);
    step_row_t s;
    s.cfg_en = ce;
    s.cfg_val = cv;
    s.req = '{o, x[19:0], y[19:0], z[19:0], r[15:0], m};
    s.typed = typed;
    s.rsp = '{st, f, h[7:0], d[17:0], c[8:0], p};
    return s;
  endfunction

  initial begin
    step_row_t plan[$];
    sphere_req_t q;
    sphere_rsp_t none;
    none = '{default: '0};
    errors = 0;
    cycles = 0;
    calm = 0;
    hold_req = 0;
    tab_count = 0;
    tab_prio = 1'b0;
    min_radius = 16'd256;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    in_valid = 1'b0;
    op = sct_pkg::OpAppend;
    pos_x = '0;
    pos_y = '0;
    pos_z = '0;
    radius = '0;
    mark = 1'b0;
    rst_n = 1'b0;
    repeat (3) @(negedge clk);
    rst_n = 1'b1;

    // Directed part: empty table, append checks in order, extremes, tie
    plan.push_back(row(0, 0, sct_pkg::OpContain, 100, 100, 100, 0, 0, 1));
    plan.push_back(row(0, 0, sct_pkg::OpOverlap, 0, 0, 0, 65535, 0, 1));
    plan.push_back(row(0, 0, sct_pkg::OpAppend, 0, 0, 0, 1000, 1, 1, sct_pkg::StOrigin));
    plan.push_back(row(0, 0, sct_pkg::OpAppend, 256, 0, 0, 255, 1, 1, sct_pkg::StSmall));
    plan.push_back(row(0, 0, sct_pkg::OpAppend, 256, 0, 0, 256, 0, 1, sct_pkg::StDone,
                       0, 0, 0, 1));
    plan.push_back(row(0, 0, sct_pkg::OpAppend, 524287, 524287, 524287, 65535, 0,
                       1, sct_pkg::StDone, 0, 0, 0, 2));
    plan.push_back(row(0, 0, sct_pkg::OpAppend, -524288, -524288, -524288, 65535, 1,
                       1, sct_pkg::StDone, 0, 0, 0, 3, 1));
    plan.push_back(row(0, 0, sct_pkg::OpContain, 256, 0, 0, 0, 0));
    plan.push_back(row(0, 0, sct_pkg::OpContain, -524288, -524288, -524288, 0, 0,
                       1, sct_pkg::StDone, 1, 2, 0, 3, 1));
    plan.push_back(row(0, 0, sct_pkg::OpContain, 524287, -524288, 0, 0, 0,
                       1, sct_pkg::StDone, 0, 0, 0, 3, 1));
    plan.push_back(row(0, 0, sct_pkg::OpOverlap, 0, 0, 0, 0, 0));
    plan.push_back(row(0, 0, sct_pkg::OpOverlap, 524287, 524287, 524287, 65535, 0,
                       1, sct_pkg::StDone, 0, 0, 131070, 3, 1));
    plan.push_back(row(0, 0, OpIdle, 5, 6, 7, 300, 1, 1, sct_pkg::StDone, 0, 0, 0, 3, 1));
    plan.push_back(row(0, 0, sct_pkg::OpAppend, 512, 0, 0, 256, 0));
    // point halfway between entries 0 and 3: equal distance, earlier wins
    plan.push_back(row(0, 0, sct_pkg::OpContain, 384, 0, 0, 0, 0, 1, sct_pkg::StDone,
                       1, 0, 0, 4, 1));
    plan.push_back(row(0, 0, sct_pkg::OpContain, 1, -1, 1, 0, 0));
    plan.push_back(row(0, 0, sct_pkg::OpOverlap, 768, 0, 0, 100, 0));
    plan.push_back(row(0, 0, OpIdle, -1, -1, -1, 65535, 1));
    plan.push_back(row(1, 0, sct_pkg::OpAppend, 0, 0, 1, 0, 1));
    plan.push_back(row(1, 16'hffff, sct_pkg::OpAppend, -1, 0, 0, 65534, 0, 1,
                       sct_pkg::StSmall, 0, 0, 0, 5, 1));
    plan.push_back(row(0, 0, sct_pkg::OpAppend, -1, 0, 0, 65535, 0));
    plan.push_back(row(0, 0, sct_pkg::OpContain, -2, 0, 0, 0, 0));
    plan.push_back(row(1, 16'd256, sct_pkg::OpOverlap, -3, 2, 1, 12345, 0));
    foreach (plan[i]) begin
      if (plan[i].cfg_en) write_min_radius(plan[i].cfg_val);
      offer(plan[i].req, plan[i].typed, plan[i].rsp);
    end

    // Random traffic on a small table
    write_min_radius(16'd128);
    run_random(650, 40);

    // Hold the receiver off long enough for the block to back up its input
    @(posedge clk);
    hold_req = 400;
    @(negedge clk);
    for (int i = 0; i < 8; i++) begin
      q = pick_req(0);
      q.op = sct_pkg::OpContain;
      offer(q, 1'b0, none);
    end
    in_valid = 1'b0;
    drain();  // sender pauses until everything is back

    write_min_radius(16'd512);
    run_random(450, 60);
    write_min_radius(16'($urandom_range(1, 300)));
    run_random(150, 60);

    // Fill the table to capacity, then run with no idling at all
    write_min_radius(16'd0);
    calm = 1;
    while (tab_count < Depth) begin
      q = pick_req(Depth);
      q.op = sct_pkg::OpAppend;
      if (q.x == 0 && q.y == 0 && q.z == 0) q.z = 3;
      offer(q, 1'b0, none);
    end
    write_min_radius(16'd300);
    run_random(60, Depth);
    in_valid = 1'b0;

    drain();
    repeat (20) @(negedge clk);
    if (errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end
endmodule

/* filelist.f */
design/sct_pkg.sv
design/sct_sqrt.sv
design/sphere_cavity_table.sv
sim/sphere_cavity_table_tb.sv
